// ----- sv/scfe_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Servo command frame encoder package
// Shared widths, character codes, byte positions, queue word type and the
// decimal digit split used by the encoder front end.
// ----------------------------------------------------------------------------
package scfe_pkg;

  // Field and datapath widths.
  localparam int ANGLE_W    = 16;
  localparam int TIME_W     = 16;
  localparam int BYTE_W     = 8;
  localparam int JIDX_W     = 3;
  localparam int VAL_W      = 14;
  localparam int DIG_W      = 4;
  localparam int BCD_W      = 4 * DIG_W;
  localparam int R_W        = 10;
  localparam int POS_W      = 5;
  localparam int S_DATA_W   = ANGLE_W + TIME_W;
  localparam int M_DATA_W   = BYTE_W;

  // Default joint count per frame.
  localparam int JOINTS_DEF = 6;

  // Arithmetic constants.
  localparam int ANGLE_LIM   = 13500;
  localparam int TIME_MAX    = 9999;
  localparam int PULSE_MID   = 1500;
  localparam int PULSE_MIN   = 500;
  localparam int PULSE_MAX   = 2500;
  localparam int ROUND_ADD   = 27;
  // floor(x / 54) == (x * RECIP) >> RECIP_SHIFT for every x below 2^16.
  localparam int RECIP       = 77673;
  localparam int RECIP_SHIFT = 22;

  // Queue between front end and byte sequencer.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // ASCII characters of the frame.
  localparam logic [BYTE_W-1:0] CH_OPEN  = 8'h7B; // '{'
  localparam logic [BYTE_W-1:0] CH_CLOSE = 8'h7D; // '}'
  localparam logic [BYTE_W-1:0] CH_HASH  = 8'h23; // '#'
  localparam logic [BYTE_W-1:0] CH_P     = 8'h50; // 'P'
  localparam logic [BYTE_W-1:0] CH_T     = 8'h54; // 'T'
  localparam logic [BYTE_W-1:0] CH_BANG  = 8'h21; // '!'
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30; // '0'

  // Byte positions within one joint's output.
  localparam logic [POS_W-1:0] POS_OPEN  = 5'd0;
  localparam logic [POS_W-1:0] POS_HASH  = 5'd1;
  localparam logic [POS_W-1:0] POS_ID2   = 5'd2;
  localparam logic [POS_W-1:0] POS_ID1   = 5'd3;
  localparam logic [POS_W-1:0] POS_ID0   = 5'd4;
  localparam logic [POS_W-1:0] POS_P     = 5'd5;
  localparam logic [POS_W-1:0] POS_PD3   = 5'd6;
  localparam logic [POS_W-1:0] POS_PD2   = 5'd7;
  localparam logic [POS_W-1:0] POS_PD1   = 5'd8;
  localparam logic [POS_W-1:0] POS_PD0   = 5'd9;
  localparam logic [POS_W-1:0] POS_T     = 5'd10;
  localparam logic [POS_W-1:0] POS_TD3   = 5'd11;
  localparam logic [POS_W-1:0] POS_TD2   = 5'd12;
  localparam logic [POS_W-1:0] POS_TD1   = 5'd13;
  localparam logic [POS_W-1:0] POS_TD0   = 5'd14;
  localparam logic [POS_W-1:0] POS_BANG  = 5'd15;
  localparam logic [POS_W-1:0] POS_CLOSE = 5'd16;

  // One encoded joint command, as held in the queue.
  typedef struct packed {
    logic              first;
    logic              last;
    logic [JIDX_W-1:0] jidx;
    logic [BCD_W-1:0]  pulse_bcd;
    logic [BCD_W-1:0]  time_bcd;
  } cmd_t;

  // One decimal digit taken off the top of a value.
  typedef struct packed {
    logic [DIG_W-1:0] digit;
    logic [VAL_W-1:0] rest;
  } dsplit_t;

  // Splits off the digit of weight base from v (v below 10*base) by nine
  // parallel compares against the multiples of base.
  function automatic dsplit_t digit_split(input logic [VAL_W-1:0] v, input int base);
    dsplit_t          res;
    logic [VAL_W-1:0] sub;
    res.digit = '0;
    sub       = '0;
    for (int k = 1; k < 10; k++) begin
      if (v >= VAL_W'(base * k)) begin
        res.digit = DIG_W'(k);
        sub       = VAL_W'(base * k);
      end
    end
    res.rest = v - sub;
    return res;
  endfunction

endpackage
`default_nettype wire

// ----- sv/scfe_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Servo command frame encoder front end
// Accepts joint words, tracks the joint index and frame time, converts the
// angle to a pulse width and both pulse and time to decimal digits in a
// five-stage pipeline that stalls as a whole when the queue is full.
// ----------------------------------------------------------------------------
module scfe_front #(
  parameter int JOINTS = scfe_pkg::JOINTS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic signed [scfe_pkg::ANGLE_W-1:0] angle_centideg,
  input  wire logic [scfe_pkg::TIME_W-1:0]    move_time_ms,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output scfe_pkg::cmd_t                      out_cmd
);

  localparam int VW = scfe_pkg::VAL_W;
  localparam logic [scfe_pkg::JIDX_W-1:0] JLAST = scfe_pkg::JIDX_W'(JOINTS - 1);

  // Per-stage control and payload.
  typedef struct packed {
    logic                        first;
    logic                        last;
    logic [scfe_pkg::JIDX_W-1:0] jidx;
  } tag_t;

  typedef struct packed {
    logic [scfe_pkg::BCD_W-1:0] pdig;
    logic [VW-1:0]              prem;
    logic [scfe_pkg::BCD_W-1:0] tdig;
    logic [VW-1:0]              trem;
  } dig_t;

  logic                        adv;
  logic                        accept;
  logic [scfe_pkg::JIDX_W-1:0] joint_index;
  logic [VW-1:0]               frame_time;

  logic v1, v2, v3, v4, v5;
  tag_t t1, t2, t3, t4, t5;
  logic [VW-1:0] ft1, ft2;
  logic neg1, neg2;
  logic [VW-1:0] m1;
  logic [scfe_pkg::R_W-1:0] r2;
  dig_t d3, d4;
  logic [scfe_pkg::BCD_W-1:0] pdig5;
  logic [scfe_pkg::BCD_W-1:0] tdig5;

  // The pipeline moves when its last stage is empty or the queue takes it.
  assign adv       = !v5 || out_ready;
  assign in_ready  = adv;
  assign accept    = in_valid && adv;
  assign out_valid = v5;

  // Stage 1 inputs: clamp and magnitude of the angle, saturated time.
  logic signed [scfe_pkg::ANGLE_W:0] a_ext;
  logic [scfe_pkg::ANGLE_W:0]        mag;
  logic [VW-1:0]                     m_clamp;
  logic [VW-1:0]                     t_sat;
  tag_t                              t_in;
  logic [VW-1:0]                     ft_in;

  always_comb begin
    a_ext   = (scfe_pkg::ANGLE_W + 1)'(angle_centideg);
    mag     = a_ext[scfe_pkg::ANGLE_W] ? (scfe_pkg::ANGLE_W + 1)'(-a_ext)
                                       : (scfe_pkg::ANGLE_W + 1)'(a_ext);
    m_clamp = (mag > (scfe_pkg::ANGLE_W + 1)'(scfe_pkg::ANGLE_LIM))
              ? VW'(scfe_pkg::ANGLE_LIM) : mag[VW-1:0];
    t_sat   = (move_time_ms > scfe_pkg::TIME_W'(scfe_pkg::TIME_MAX))
              ? VW'(scfe_pkg::TIME_MAX) : move_time_ms[VW-1:0];
    t_in.first = (joint_index == '0);
    t_in.last  = (joint_index == JLAST);
    t_in.jidx  = joint_index;
    ft_in      = (joint_index == '0) ? t_sat : frame_time;
  end

  // Joint index and latched frame time.
  always_ff @(posedge clk) begin
    if (rst) begin
      joint_index <= '0;
      frame_time  <= '0;
    end else if (accept) begin
      joint_index <= (joint_index == JLAST) ? '0 : joint_index + 1'b1;
      if (joint_index == '0) begin
        frame_time <= t_sat;
      end
    end
  end

  // Stage 2 arithmetic: r = floor((4m + 27) / 54) by reciprocal multiply.
  logic [15:0] xnum;
  logic [32:0] prod;

  always_comb begin
    xnum = {m1, 2'b00} + 16'(scfe_pkg::ROUND_ADD);
    prod = 33'(xnum) * 33'(scfe_pkg::RECIP);
  end

  // Stage 3 to 5 arithmetic: signed pulse, clamp, thousands, hundreds and tens digits.
  logic [VW-1:0]      pulse;
  scfe_pkg::dsplit_t  p_th, t_th;
  scfe_pkg::dsplit_t  p_hu, t_hu;
  scfe_pkg::dsplit_t  p_te, t_te;

  always_comb begin
    pulse = neg2 ? VW'(scfe_pkg::PULSE_MID) - VW'(r2)
                 : VW'(scfe_pkg::PULSE_MID) + VW'(r2);
    if (pulse < VW'(scfe_pkg::PULSE_MIN)) begin
      pulse = VW'(scfe_pkg::PULSE_MIN);
    end else if (pulse > VW'(scfe_pkg::PULSE_MAX)) begin
      pulse = VW'(scfe_pkg::PULSE_MAX);
    end
    p_th = scfe_pkg::digit_split(pulse, 1000);
    t_th = scfe_pkg::digit_split(ft2, 1000);
    p_hu = scfe_pkg::digit_split(d3.prem, 100);
    t_hu = scfe_pkg::digit_split(d3.trem, 100);
    p_te = scfe_pkg::digit_split(d4.prem, 10);
    t_te = scfe_pkg::digit_split(d4.trem, 10);
  end

  // Pipeline valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (adv) begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk) begin
    if (adv) begin
      t1   <= t_in;
      ft1  <= ft_in;
      neg1 <= angle_centideg[scfe_pkg::ANGLE_W-1];
      m1   <= m_clamp;

      t2   <= t1;
      ft2  <= ft1;
      neg2 <= neg1;
      r2   <= prod[scfe_pkg::RECIP_SHIFT +: scfe_pkg::R_W];

      t3      <= t2;
      d3.pdig <= {p_th.digit, 12'h000};
      d3.prem <= p_th.rest;
      d3.tdig <= {t_th.digit, 12'h000};
      d3.trem <= t_th.rest;

      t4      <= t3;
      d4.pdig <= {d3.pdig[15:12], p_hu.digit, 8'h00};
      d4.prem <= p_hu.rest;
      d4.tdig <= {d3.tdig[15:12], t_hu.digit, 8'h00};
      d4.trem <= t_hu.rest;

      t5    <= t4;
      pdig5 <= {d4.pdig[15:8], p_te.digit, p_te.rest[3:0]};
      tdig5 <= {d4.tdig[15:8], t_te.digit, t_te.rest[3:0]};
    end
  end

  // Queue word.
  always_comb begin
    out_cmd.first     = t5.first;
    out_cmd.last      = t5.last;
    out_cmd.jidx      = t5.jidx;
    out_cmd.pulse_bcd = pdig5;
    out_cmd.time_bcd  = tdig5;
  end

endmodule
`default_nettype wire

// ----- sv/scfe_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Servo command frame encoder queue
// Short first-in first-out buffer of encoded joint commands between the
// front end and the byte sequencer.
// ----------------------------------------------------------------------------
module scfe_queue (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push_valid,
  output logic        push_ready,
  input  scfe_pkg::cmd_t push_cmd,
  output logic        pop_valid,
  input  wire logic   pop,
  output scfe_pkg::cmd_t pop_cmd
);

  scfe_pkg::cmd_t                 mem [scfe_pkg::QUEUE_DEPTH];
  logic [scfe_pkg::QPTR_W-1:0]    wr_ptr;
  logic [scfe_pkg::QPTR_W-1:0]    rd_ptr;
  logic [scfe_pkg::QCNT_W-1:0]    count;
  logic                           do_push;
  logic                           do_pop;

  assign push_ready = (count != scfe_pkg::QCNT_W'(scfe_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_cmd    = mem[rd_ptr];

  // Pointer wrap at the queue depth.
  function automatic logic [scfe_pkg::QPTR_W-1:0] ptr_inc(
    input logic [scfe_pkg::QPTR_W-1:0] p
  );
    return (p == scfe_pkg::QPTR_W'(scfe_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

// ----- sv/scfe_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Servo command frame encoder byte sequencer
// Walks the byte positions of the command at the head of the queue and
// sends one ASCII byte per word through a registered output stage.
// ----------------------------------------------------------------------------
module scfe_back (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cmd_valid,
  output logic                              cmd_pop,
  input  scfe_pkg::cmd_t                    cmd,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [scfe_pkg::BYTE_W-1:0]       out_byte,
  output logic                              out_last
);

  logic [scfe_pkg::POS_W-1:0]  pos;
  logic [scfe_pkg::POS_W-1:0]  eff;
  logic                        out_free;
  logic                        step;
  logic                        final_byte;
  logic [scfe_pkg::BYTE_W-1:0] ch;

  // Joint 0 starts with the opening brace; other joints skip it.
  always_comb begin
    eff        = (pos == scfe_pkg::POS_OPEN && !cmd.first) ? scfe_pkg::POS_HASH : pos;
    final_byte = (eff == scfe_pkg::POS_CLOSE) || (eff == scfe_pkg::POS_BANG && !cmd.last);
    out_free   = !out_valid || out_ready;
    step       = out_free && cmd_valid;
    cmd_pop    = step && final_byte;
  end

  function automatic logic [scfe_pkg::BYTE_W-1:0] dig_ch(input logic [3:0] d);
    return scfe_pkg::CH_ZERO + {4'h0, d};
  endfunction

  // Character at the current position.
  always_comb begin
    case (eff)
      scfe_pkg::POS_OPEN:  ch = scfe_pkg::CH_OPEN;
      scfe_pkg::POS_HASH:  ch = scfe_pkg::CH_HASH;
      scfe_pkg::POS_ID2:   ch = scfe_pkg::CH_ZERO;
      scfe_pkg::POS_ID1:   ch = scfe_pkg::CH_ZERO;
      scfe_pkg::POS_ID0:   ch = dig_ch({1'b0, cmd.jidx});
      scfe_pkg::POS_P:     ch = scfe_pkg::CH_P;
      scfe_pkg::POS_PD3:   ch = dig_ch(cmd.pulse_bcd[15:12]);
      scfe_pkg::POS_PD2:   ch = dig_ch(cmd.pulse_bcd[11:8]);
      scfe_pkg::POS_PD1:   ch = dig_ch(cmd.pulse_bcd[7:4]);
      scfe_pkg::POS_PD0:   ch = dig_ch(cmd.pulse_bcd[3:0]);
      scfe_pkg::POS_T:     ch = scfe_pkg::CH_T;
      scfe_pkg::POS_TD3:   ch = dig_ch(cmd.time_bcd[15:12]);
      scfe_pkg::POS_TD2:   ch = dig_ch(cmd.time_bcd[11:8]);
      scfe_pkg::POS_TD1:   ch = dig_ch(cmd.time_bcd[7:4]);
      scfe_pkg::POS_TD0:   ch = dig_ch(cmd.time_bcd[3:0]);
      scfe_pkg::POS_BANG:  ch = scfe_pkg::CH_BANG;
      scfe_pkg::POS_CLOSE: ch = scfe_pkg::CH_CLOSE;
      default:             ch = scfe_pkg::CH_ZERO;
    endcase
  end

  // Position counter and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= scfe_pkg::POS_OPEN;
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= cmd_valid;
      if (cmd_valid) begin
        pos <= final_byte ? scfe_pkg::POS_OPEN : eff + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_byte <= ch;
      out_last <= final_byte;
    end
  end

endmodule
`default_nettype wire

// ----- sv/servo_command_frame_encoder_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// A joint's bytes pass the front-end stages, the queue and the output register.
// Throughput: 15 bytes per joint, 16 on the first or last joint of a frame
// (17 with a single joint), one byte per cycle while m_axis_tready holds.
// The front end takes a new joint word every cycle until its queue fills.
// Reset clears the joint index, the frame time, all valid bits and the queue.
// ----------------------------------------------------------------------------
// Servo command frame encoder
// Turns joint angles into ASCII servo command frames, one byte per word.
// ----------------------------------------------------------------------------
module servo_command_frame_encoder_unit #(
  parameter int JOINTS = scfe_pkg::JOINTS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // [15:0] angle_centideg, [31:16] move_time_ms
  input  wire logic [scfe_pkg::S_DATA_W-1:0]    s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // [7:0] frame_byte
  output logic [scfe_pkg::M_DATA_W-1:0]         m_axis_tdata,
  // last_byte
  output logic                                  m_axis_tlast
);

  logic           f_valid;
  logic           f_ready;
  scfe_pkg::cmd_t f_cmd;
  logic           q_valid;
  logic           q_pop;
  scfe_pkg::cmd_t q_cmd;

  // Front end: pulse and digit conversion.
  scfe_front #(
    .JOINTS(JOINTS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_axis_tvalid),
    .in_ready      (s_axis_tready),
    .angle_centideg(s_axis_tdata[scfe_pkg::ANGLE_W-1:0]),
    .move_time_ms  (s_axis_tdata[scfe_pkg::S_DATA_W-1:scfe_pkg::ANGLE_W]),
    .out_valid     (f_valid),
    .out_ready     (f_ready),
    .out_cmd       (f_cmd)
  );

  // Command queue.
  scfe_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(f_valid),
    .push_ready(f_ready),
    .push_cmd  (f_cmd),
    .pop_valid (q_valid),
    .pop       (q_pop),
    .pop_cmd   (q_cmd)
  );

  // Byte sequencer.
  scfe_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(q_valid),
    .cmd_pop  (q_pop),
    .cmd      (q_cmd),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_byte (m_axis_tdata),
    .out_last (m_axis_tlast)
  );

endmodule
`default_nettype wire

// ----- verif/servo_command_frame_encoder_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Servo command frame encoder testbench
// Streams joint words into the encoder. A scoreboard predicts the ASCII frame
// bytes for every accepted word and compares each outgoing byte and its last
// flag in order. Both sides draw random gaps per word. One long stall on the
// output side lets the encoder fill up and push back on its input.
// ----------------------------------------------------------------------------
module servo_command_frame_encoder_unit_test;
  import scfe_pkg::*;

  localparam int NUM_JOINTS   = JOINTS_DEF;
  localparam int RANDOM_WORDS = 106;
  localparam int HOLD_AT_BYTE = 600;
  localparam int HOLD_CYCLES  = 300;
  localparam int MAX_REPORTS  = 10;

  // One expected output word: a frame character and its last flag.
  typedef struct packed {
    logic [BYTE_W-1:0] ch;
    logic              last;
  } frame_char_t;

  // Predicts the frame bytes of each joint word and checks the output stream.
  class frame_scoreboard;
    int unsigned       next_joint;
    logic [VAL_W-1:0]  latched_ms;
    frame_char_t       expected_q[$];
    int                errors;

    function new();
      next_joint = 0;
      latched_ms = '0;
      errors     = 0;
    endfunction

    function void push_char(logic [BYTE_W-1:0] ch);
      frame_char_t fc;
      fc.ch   = ch;
      fc.last = 1'b0;
      expected_q.push_back(fc);
    endfunction

    // Pushes v as count decimal digits, most significant first.
    function void push_decimal(int unsigned v, int count);
      int unsigned div;
      div = 1;
      for (int i = 1; i < count; i++) div *= 10;
      for (int i = 0; i < count; i++) begin
        push_char(CH_ZERO + BYTE_W'((v / div) % 10));
        div /= 10;
      end
    endfunction

    // Pulse width in microseconds for an angle in hundredths of a degree.
    function int unsigned pulse_of(logic signed [ANGLE_W-1:0] angle);
      int a;
      int mag;
      int r;
      int p;
      a = angle;
      if (a < -ANGLE_LIM) a = -ANGLE_LIM;
      if (a > ANGLE_LIM) a = ANGLE_LIM;
      mag = (a < 0) ? -a : a;
      // Rounds 2*mag/27 half away from zero.
      r = (4 * mag + 27) / 54;
      p = (a < 0) ? PULSE_MID - r : PULSE_MID + r;
      if (p < PULSE_MIN) p = PULSE_MIN;
      if (p > PULSE_MAX) p = PULSE_MAX;
      return p;
    endfunction

    function void note_joint(logic signed [ANGLE_W-1:0] angle,
                             logic [TIME_W-1:0] move_ms);
      int unsigned joint;
      frame_char_t fc;
      joint = next_joint;
      // The move time is taken only on the first joint of a frame.
      if (joint == 0) begin
        latched_ms = (move_ms > TIME_MAX) ? VAL_W'(TIME_MAX) : move_ms[VAL_W-1:0];
        push_char(CH_OPEN);
      end
      push_char(CH_HASH);
      push_decimal(joint, 3);
      push_char(CH_P);
      push_decimal(pulse_of(angle), 4);
      push_char(CH_T);
      push_decimal(latched_ms, 4);
      push_char(CH_BANG);
      if (joint + 1 >= NUM_JOINTS) begin
        push_char(CH_CLOSE);
        next_joint = 0;
      end else begin
        next_joint = joint + 1;
      end
      fc = expected_q.pop_back();
      fc.last = 1'b1;
      expected_q.push_back(fc);
    endfunction

    function void check_byte(logic [BYTE_W-1:0] ch, logic last);
      frame_char_t fc;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("Unexpected word: byte %h last %b", ch, last);
        return;
      end
      fc = expected_q.pop_front();
      if (fc.ch !== ch || fc.last !== last) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("Mismatch: expected byte %h last %b, got byte %h last %b",
                   fc.ch, fc.last, ch, last);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Anything still waiting at the end is a missing output word.
    function void close_out();
      if (expected_q.size() != 0) begin
        errors += expected_q.size();
        $display("Missing %0d output words at end of run", expected_q.size());
      end
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [S_DATA_W-1:0] s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [M_DATA_W-1:0] m_axis_tdata;
  logic                m_axis_tlast;

  frame_scoreboard     sb;

  servo_command_frame_encoder_unit uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // 100 MHz clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Offers one joint word after the idle gap given by gap and waits until it is taken.
  // Called at a falling edge and returns at a falling edge.
  task automatic send_joint(logic signed [ANGLE_W-1:0] angle,
                            logic [TIME_W-1:0] move_ms, int gap);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {move_ms, angle};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_joint(angle, move_ms);
    @(negedge clk);
  endtask

  // Random angle: full range, in range, near the clamp limits or near zero.
  function automatic logic [ANGLE_W-1:0] pick_angle();
    int a;
    case ($urandom_range(0, 3))
      0: a = $urandom_range(0, 65535) - 32768;
      1: a = $urandom_range(0, 2 * ANGLE_LIM) - ANGLE_LIM;
      2: a = ($urandom_range(0, 1) ? ANGLE_LIM : -ANGLE_LIM) + $urandom_range(0, 8) - 4;
      default: a = $urandom_range(0, 60) - 30;
    endcase
    return ANGLE_W'(a);
  endfunction

  // Output side: random stalls per word, fast stretches and one long hold.
  initial begin : byte_sink
    int bytes_seen;
    int gap;
    bit held;
    bytes_seen    = 0;
    held          = 1'b0;
    m_axis_tready = 1'b0;
    @(negedge clk);
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      if (!held && bytes_seen == HOLD_AT_BYTE) begin
        held          = 1'b1;
        m_axis_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      gap = ((bytes_seen / 150) % 3 == 1) ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        m_axis_tready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_axis_tready = 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
      sb.check_byte(m_axis_tdata, m_axis_tlast);
      bytes_seen++;
      @(negedge clk);
    end
  end

  // Input side: directed frames, then random frames.
  initial begin : joint_source
    logic signed [ANGLE_W-1:0] dir_angle [24];
    logic [TIME_W-1:0]         dir_ms    [24];
    int gap;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    sb            = new();
    repeat (12) @(negedge clk);
    rst = 1'b0;

    // Clamp limits, rounding edges around zero and the time saturation.
    // The time on joints other than the first should be ignored.
    dir_angle = '{-16'sd32768, 16'sd32767, -16'sd13500, 16'sd13500, -16'sd13501, 16'sd13501,
                  16'sd0, 16'sd1, -16'sd1, 16'sd6, 16'sd7, -16'sd7,
                  16'sd13, 16'sd14, -16'sd14, 16'sd1000, -16'sd1000, 16'sd27,
                  16'sd13499, -16'sd13499, 16'sd20000, -16'sd20000, 16'sd135, -16'sd135};
    dir_ms    = '{16'd0, 16'hFFFF, 16'd9999, 16'd10000, 16'd1, 16'd0,
                  16'hFFFF, 16'd0, 16'd1234, 16'hAAAA, 16'h5555, 16'd9999,
                  16'd9999, 16'd0, 16'hFFFF, 16'd42, 16'd7, 16'd10000,
                  16'd10000, 16'd0, 16'd9999, 16'hFFFF, 16'd500, 16'd3};
    foreach (dir_angle[i]) send_joint(dir_angle[i], dir_ms[i], $urandom_range(0, 10));

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      // Every fourth stretch of twenty words goes back to back.
      gap = ((i / 20) % 4 == 2) ? 0 : $urandom_range(0, 10);
      send_joint(pick_angle(),
                 ($urandom_range(0, 3) == 0) ? TIME_W'($urandom_range(0, 65535))
                                             : TIME_W'($urandom_range(0, TIME_MAX)),
                 gap);
    end
    s_axis_tvalid = 1'b0;

    while (sb.pending() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
    sb.close_out();
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/scfe_pkg.sv
sv/scfe_front.sv
sv/scfe_queue.sv
sv/scfe_back.sv
sv/servo_command_frame_encoder_unit.sv
verif/servo_command_frame_encoder_unit_test.sv
